@@ rtl/st25_pkg.sv @@
package st25_pkg;

    // grid geometry
    localparam int C_MAX_WIDTH     = 1024;
    localparam int C_COL_BITS      = $clog2(C_MAX_WIDTH);
    localparam int C_ROW_BITS      = 16;
    localparam int C_WREG_BITS     = 11;
    localparam int C_SAMPLE_BITS   = 32;
    localparam int C_LINES         = 4;
    localparam int C_WORD_BITS     = C_LINES * C_SAMPLE_BITS;
    localparam int C_WIN           = 5;

    // configuration port
    localparam int C_CFG_IDX_BITS  = 1;
    localparam int C_CFG_DATA_BITS = 16;
    localparam logic [C_CFG_IDX_BITS-1:0] C_REG_GRID_WIDTH  = 1'd0;
    localparam logic [C_CFG_IDX_BITS-1:0] C_REG_GRID_HEIGHT = 1'd1;

    // arithmetic widths
    localparam int C_RSUM_BITS     = 38;
    localparam int C_TOTAL_BITS    = 40;
    localparam int C_MAG_BITS      = 38;
    localparam int C_PROD_BITS     = 77;

    // divide by 59 after halving: floor(m * C_RECIP / 2^44) == floor(m / 59) for m < 2^38
    localparam logic [38:0] C_RECIP       = 39'd298172644821;
    localparam int          C_RECIP_SHIFT = 44;

    localparam logic [4:0] C_WEIGHT [C_WIN][C_WIN] = '{
        '{5'd1,  5'd2,  5'd3,  5'd4,  5'd5 },
        '{5'd7,  5'd7,  5'd5,  5'd7,  5'd6 },
        '{5'd8,  5'd12, 5'd15, 5'd12, 5'd12},
        '{5'd9,  5'd9,  5'd5,  5'd7,  5'd15},
        '{5'd10, 5'd11, 5'd12, 5'd13, 5'd14}
    };

    typedef logic signed [C_SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [C_RSUM_BITS-1:0]   t_rsum;
    typedef logic signed [C_TOTAL_BITS-1:0]  t_total;

endpackage

@@ rtl/st25_ram.sv @@
module st25_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

endmodule

@@ rtl/stencil_25pt_clamped_2d.sv @@
// channel   | direction | handshake                   | payload
// ----------+-----------+-----------------------------+---------------------------------------
// input     | in        | i_in_valid / o_in_stall     | i_sample_in
// output    | out       | o_out_valid / i_out_stall   | o_result_value, o_last_of_run,
//           |           |                             | o_end_of_frame
// config    | in        | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// one input item per cycle unless stalled; an item with n result items holds the window stage
// until its last result issues (n up to 9 at a row end of the last row); output stalls also hold it
// an input item reaches its first result item through seven register stages
// (line ram read, window, gather, row sums, total, reciprocal partial products, output)
// synchronous active-low reset clears control state, sizes go to 1024 x 1024
// the line ram holds no reset state; rows are always rewritten before they are read
// a stall on the output backs up through the stage ready chain into o_in_stall, filling empty stages first
module stencil_25pt_clamped_2d (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [st25_pkg::C_SAMPLE_BITS-1:0] i_sample_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [st25_pkg::C_SAMPLE_BITS-1:0] o_result_value,
    output logic                                  o_last_of_run,
    output logic                                  o_end_of_frame,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [st25_pkg::C_CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [st25_pkg::C_CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int CB = st25_pkg::C_COL_BITS;
    localparam int RB = st25_pkg::C_ROW_BITS;
    localparam int SB = st25_pkg::C_SAMPLE_BITS;
    localparam int WB = st25_pkg::C_WORD_BITS;
    localparam int NW = st25_pkg::C_WIN;

    // ---------------- configuration ----------------
    logic [st25_pkg::C_WREG_BITS-1:0] r_grid_width;
    logic [RB-1:0]                    r_grid_height;
    logic                             cfg_we;
    logic [st25_pkg::C_WREG_BITS-1:0] w_eff;
    logic [RB-1:0]                    h_eff;
    logic [CB-1:0]                    w_last;
    logic [RB-1:0]                    h_last;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= st25_pkg::C_WREG_BITS'(st25_pkg::C_MAX_WIDTH);
            r_grid_height <= RB'(1024);
        end else if (cfg_we) begin
            case (i_cfg_index)
                st25_pkg::C_REG_GRID_WIDTH:  r_grid_width  <= i_cfg_data[st25_pkg::C_WREG_BITS-1:0];
                st25_pkg::C_REG_GRID_HEIGHT: r_grid_height <= i_cfg_data[RB-1:0];
                default: ;
            endcase
        end
    end

    // zero counts as one, width saturates at the line length
    always_comb begin
        if (r_grid_width == '0) begin
            w_eff = st25_pkg::C_WREG_BITS'(1);
        end else if (r_grid_width > st25_pkg::C_WREG_BITS'(st25_pkg::C_MAX_WIDTH)) begin
            w_eff = st25_pkg::C_WREG_BITS'(st25_pkg::C_MAX_WIDTH);
        end else begin
            w_eff = r_grid_width;
        end
        h_eff  = (r_grid_height == '0) ? RB'(1) : r_grid_height;
        w_last = CB'(w_eff - st25_pkg::C_WREG_BITS'(1));
        h_last = h_eff - RB'(1);
    end

    // ---------------- handshake chain ----------------
    logic in_acc, s1_move, w_free, issue, w_last_pt;
    logic p1_rdy, p2_rdy, p3_rdy, p4_rdy, p5_rdy;

    logic r_p1_v, r_p2_v, r_p3_v, r_p4_v, r_p5_v;
    logic r_v1, r_wv, r_has;

    assign p5_rdy  = !r_p5_v || !i_out_stall;
    assign p4_rdy  = !r_p4_v || p5_rdy;
    assign p3_rdy  = !r_p3_v || p4_rdy;
    assign p2_rdy  = !r_p2_v || p3_rdy;
    assign p1_rdy  = !r_p1_v || p2_rdy;

    logic [RB-1:0] r_cy, r_y1, r_y0;
    logic [CB-1:0] r_cx, r_x1, r_x0;

    assign w_last_pt = (r_cx == r_x1) && (r_cy == r_y1);
    assign issue     = r_wv && r_has && p1_rdy;
    // window stage frees when it had nothing to emit or emits its last point now
    assign w_free    = !r_wv || !r_has || (issue && w_last_pt);
    assign s1_move   = r_v1 && w_free;
    assign o_in_stall = r_v1 && !s1_move;
    assign in_acc    = i_in_valid && !o_in_stall;

    // ---------------- input position ----------------
    logic [CB-1:0] r_col;
    logic [RB-1:0] r_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_we) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (r_col == w_last) begin
                r_col <= '0;
                r_row <= (r_row == h_last) ? '0 : r_row + RB'(1);
            end else begin
                r_col <= r_col + CB'(1);
            end
        end
    end

    // ---------------- line ram stage ----------------
    // one ram word per column holds the last four rows, oldest in the low lane
    logic [WB-1:0] ram_rdata, old_word, new_word, r_wword;
    st25_pkg::t_sample r_s1_sample;
    logic [CB-1:0]     r_s1_col;
    logic [RB-1:0]     r_s1_row;
    logic              r_fwd;

    st25_ram #(
        .WIDTH (WB),
        .DEPTH (st25_pkg::C_MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (s1_move),
        .i_waddr (r_s1_col),
        .i_wdata (new_word),
        .i_re    (in_acc),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // a one-column grid reads the word that is being written in the same cycle
    assign old_word = r_fwd ? r_wword : ram_rdata;
    assign new_word = {r_s1_sample, old_word[WB-1:SB]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_fwd <= 1'b0;
        end else begin
            if (in_acc) begin
                r_v1  <= 1'b1;
                r_fwd <= s1_move && (r_s1_col == r_col);
            end else if (s1_move) begin
                r_v1  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_sample <= i_sample_in;
            r_s1_col    <= r_col;
            r_s1_row    <= r_row;
        end
        if (s1_move) begin
            r_wword <= new_word;
        end
    end

    // ---------------- window stage ----------------
    st25_pkg::t_sample r_win [NW][NW];
    logic [RB-1:0]     r_wrow;
    logic [CB-1:0]     r_wcol;
    logic              ent_ylast, ent_xlast, ent_hasy, ent_hasx;
    logic [RB-1:0]     ent_y0, ent_y1;
    logic [CB-1:0]     ent_x0, ent_x1;

    always_comb begin
        ent_ylast = (r_s1_row == h_last);
        ent_xlast = (r_s1_col == w_last);
        ent_hasy  = ent_ylast || (r_s1_row >= RB'(2));
        ent_hasx  = ent_xlast || (r_s1_col >= CB'(2));
        ent_y0    = (r_s1_row >= RB'(2)) ? r_s1_row - RB'(2) : '0;
        ent_x0    = (r_s1_col >= CB'(2)) ? r_s1_col - CB'(2) : '0;
        ent_y1    = ent_ylast ? r_s1_row : r_s1_row - RB'(2);
        ent_x1    = ent_xlast ? r_s1_col : r_s1_col - CB'(2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv <= 1'b0;
        end else if (s1_move) begin
            r_wv <= 1'b1;
        end else if (w_free) begin
            r_wv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            for (int k = 0; k < NW; k++) begin
                for (int j = 0; j < NW - 1; j++) begin
                    r_win[k][j] <= r_win[k][j+1];
                end
            end
            for (int k = 0; k < NW - 1; k++) begin
                r_win[k][NW-1] <= old_word[k*SB +: SB];
            end
            r_win[NW-1][NW-1] <= r_s1_sample;
            r_wrow <= r_s1_row;
            r_wcol <= r_s1_col;
            r_has  <= ent_hasy && ent_hasx;
            r_y0   <= ent_y0;
            r_y1   <= ent_y1;
            r_x0   <= ent_x0;
            r_x1   <= ent_x1;
            r_cy   <= ent_y0;
            r_cx   <= ent_x0;
        end else if (issue) begin
            if (r_cx == r_x1) begin
                r_cx <= r_x0;
                r_cy <= r_cy + RB'(1);
            end else begin
                r_cx <= r_cx + CB'(1);
            end
        end
    end

    // clamped neighbourhood, mapped onto window rows and columns
    logic [2:0]        krow [NW];
    logic [2:0]        jcol [NW];
    st25_pkg::t_sample gath [NW][NW];

    always_comb begin
        logic signed [RB+1:0] ty, ky;
        logic signed [RB+1:0] tx, kx;
        for (int d = 0; d < NW; d++) begin
            ty = $signed({2'b00, r_cy}) + (RB+2)'(d) - (RB+2)'(2);
            if (ty < 0) begin
                ty = '0;
            end else if (ty > $signed({2'b00, h_last})) begin
                ty = $signed({2'b00, h_last});
            end
            ky = ty - $signed({2'b00, r_wrow}) + (RB+2)'(4);
            krow[d] = ky[2:0];

            tx = $signed({(RB+2-CB)'(0), r_cx}) + (RB+2)'(d) - (RB+2)'(2);
            if (tx < 0) begin
                tx = '0;
            end else if (tx > $signed({(RB+2-CB)'(0), w_last})) begin
                tx = $signed({(RB+2-CB)'(0), w_last});
            end
            kx = tx - $signed({(RB+2-CB)'(0), r_wcol}) + (RB+2)'(4);
            jcol[d] = kx[2:0];
        end
        for (int a = 0; a < NW; a++) begin
            for (int b = 0; b < NW; b++) begin
                case ({krow[a], jcol[b]})
                    default: gath[a][b] = r_win[(krow[a] > 3'd4) ? 3'd4 : krow[a]]
                                               [(jcol[b] > 3'd4) ? 3'd4 : jcol[b]];
                endcase
            end
        end
    end

    // ---------------- arithmetic pipeline ----------------
    st25_pkg::t_sample r_p1_g [NW][NW];
    st25_pkg::t_rsum   r_p2_rs [NW];
    logic [st25_pkg::C_MAG_BITS-1:0] r_p3_m;
    logic              r_p3_neg, r_p4_neg;
    logic [37:0]       r_p4_hh, r_p4_lh;
    logic [38:0]       r_p4_hl, r_p4_ll;
    logic              r_p1_last, r_p2_last, r_p3_last, r_p4_last;
    logic              r_p1_eof, r_p2_eof, r_p3_eof, r_p4_eof;
    st25_pkg::t_sample r_p5_val;
    logic              r_p5_last, r_p5_eof;

    st25_pkg::t_rsum   rs_next [NW];
    st25_pkg::t_total  total;
    logic [st25_pkg::C_TOTAL_BITS-1:0] mag;
    logic [st25_pkg::C_PROD_BITS-1:0]  prod;
    logic [32:0]       quo;
    st25_pkg::t_sample sat;

    always_comb begin
        for (int k = 0; k < NW; k++) begin
            rs_next[k] = '0;
            for (int j = 0; j < NW; j++) begin
                rs_next[k] = rs_next[k] + st25_pkg::C_RSUM_BITS'(r_p1_g[k][j])
                    * $signed(st25_pkg::C_RSUM_BITS'(st25_pkg::C_WEIGHT[k][j]));
            end
        end
        total = '0;
        for (int k = 0; k < NW; k++) begin
            total = total + st25_pkg::C_TOTAL_BITS'(r_p2_rs[k]);
        end
        mag  = total[st25_pkg::C_TOTAL_BITS-1] ? -total : total;
        prod = (st25_pkg::C_PROD_BITS'(r_p4_hh) << 39)
             + (st25_pkg::C_PROD_BITS'(r_p4_hl) << 19)
             + (st25_pkg::C_PROD_BITS'(r_p4_lh) << 20)
             + st25_pkg::C_PROD_BITS'(r_p4_ll);
        quo  = prod[st25_pkg::C_PROD_BITS-1:st25_pkg::C_RECIP_SHIFT];
        if (r_p4_neg) begin
            sat = (quo > 33'd2147483648) ? 32'sh8000_0000 : st25_pkg::t_sample'(-quo);
        end else begin
            sat = (quo > 33'd2147483647) ? 32'sh7fff_ffff : st25_pkg::t_sample'(quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_p4_v <= 1'b0;
            r_p5_v <= 1'b0;
        end else begin
            if (p1_rdy) r_p1_v <= issue;
            if (p2_rdy) r_p2_v <= r_p1_v;
            if (p3_rdy) r_p3_v <= r_p2_v;
            if (p4_rdy) r_p4_v <= r_p3_v;
            if (p5_rdy) r_p5_v <= r_p4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p1_rdy) begin
            r_p1_g    <= gath;
            r_p1_last <= w_last_pt;
            r_p1_eof  <= (r_cy == h_last) && (r_cx == w_last);
        end
        if (p2_rdy) begin
            r_p2_rs   <= rs_next;
            r_p2_last <= r_p1_last;
            r_p2_eof  <= r_p1_eof;
        end
        if (p3_rdy) begin
            // halve first: truncated /118 equals floor(floor(|acc|/2)/59)
            r_p3_m    <= mag[st25_pkg::C_MAG_BITS:1];
            r_p3_neg  <= total[st25_pkg::C_TOTAL_BITS-1];
            r_p3_last <= r_p2_last;
            r_p3_eof  <= r_p2_eof;
        end
        if (p4_rdy) begin
            r_p4_hh   <= 38'(r_p3_m[37:19]) * 38'(st25_pkg::C_RECIP[38:20]);
            r_p4_hl   <= 39'(r_p3_m[37:19]) * 39'(st25_pkg::C_RECIP[19:0]);
            r_p4_lh   <= 38'(r_p3_m[18:0])  * 38'(st25_pkg::C_RECIP[38:20]);
            r_p4_ll   <= 39'(r_p3_m[18:0])  * 39'(st25_pkg::C_RECIP[19:0]);
            r_p4_neg  <= r_p3_neg;
            r_p4_last <= r_p3_last;
            r_p4_eof  <= r_p3_eof;
        end
        if (p5_rdy) begin
            r_p5_val  <= sat;
            r_p5_last <= r_p4_last;
            r_p5_eof  <= r_p4_eof;
        end
    end

    assign o_out_valid    = r_p5_v;
    assign o_result_value = r_p5_val;
    assign o_last_of_run  = r_p5_last;
    assign o_end_of_frame = r_p5_eof;

`ifndef SYNTHESIS
    // the frame's final point always closes its item's run
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_frame |-> o_last_of_run)
        else $error("end of frame without last of run");

    // same-column back-to-back ram access only happens on a one-column grid
    a_fwd_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_fwd |-> (w_last == '0))
        else $error("ram forward on a wide grid");

    // point sequencer stays inside its row and column range
    a_seq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wv && r_has |-> (r_cx <= r_x1) && (r_cy <= r_y1) && (r_cx >= r_x0))
        else $error("point sequencer out of range");
`endif

endmodule

@@ sim/st25_checker.sv @@
`timescale 1ns / 100ps

module st25_checker (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_in_valid,
    input  logic                                      i_in_stall,
    input  logic signed [st25_pkg::C_SAMPLE_BITS-1:0] i_sample_in,
    input  logic                                      i_out_valid,
    input  logic                                      i_out_stall,
    input  logic signed [st25_pkg::C_SAMPLE_BITS-1:0] i_result_value,
    input  logic                                      i_last_of_run,
    input  logic                                      i_end_of_frame,
    input  logic                                      i_cfg_valid,
    input  logic                                      i_cfg_ready,
    input  logic [st25_pkg::C_CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [st25_pkg::C_CFG_DATA_BITS-1:0]      i_cfg_data,
    output int                                        o_errors,
    output int                                        o_pending
);

    typedef struct {
        st25_pkg::t_sample value;
        logic              last;
        logic              eof;
    } t_point;

    localparam int TAP [5][5] = '{
        '{1,  2,  3,  4,  5 },
        '{7,  7,  5,  7,  6 },
        '{8,  12, 15, 12, 12},
        '{9,  9,  5,  7,  15},
        '{10, 11, 12, 13, 14}
    };

    logic [st25_pkg::C_WREG_BITS-1:0] width_reg;
    logic [st25_pkg::C_ROW_BITS-1:0]  height_reg;
    st25_pkg::t_sample      rows_mem [st25_pkg::C_LINES][st25_pkg::C_MAX_WIDTH];
    longint                 win [5][5];
    int                     col_pos;
    int                     row_pos;
    t_point                 points_due [$];
    int                     errors;

    assign o_errors  = errors;

    function automatic st25_pkg::t_sample stencil_point(int y, int x, int r, int c,
                                                        int w, int h);
        longint acc;
        longint q;
        int     k;
        int     j;
        int     yy;
        int     xx;
        acc = 0;
        for (int dy = 0; dy < 5; dy++) begin
            yy = y - 2 + dy;
            yy = yy < 0 ? 0 : (yy > h - 1 ? h - 1 : yy);
            k  = yy - (r - 4);
            if (k & 4) k = 4;
            for (int dx = 0; dx < 5; dx++) begin
                xx = x - 2 + dx;
                xx = xx < 0 ? 0 : (xx > w - 1 ? w - 1 : xx);
                j  = xx - (c - 4);
                if (j & 4) j = 4;
                acc += longint'(TAP[dy][dx]) * win[k][j];
            end
        end
        q = acc / 118;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return st25_pkg::t_sample'(q);
    endfunction

    task automatic predict_points(input st25_pkg::t_sample s);
        int     w;
        int     h;
        int     r;
        int     c;
        int     y0;
        int     y1;
        int     x0;
        int     x1;
        int     n;
        t_point run [9];
        w = width_reg == 0 ? 1 : (width_reg > st25_pkg::C_MAX_WIDTH ?
            st25_pkg::C_MAX_WIDTH : int'(width_reg));
        h = height_reg == 0 ? 1 : int'(height_reg);
        r = row_pos;
        c = col_pos;
        for (int k = 0; k < 5; k++)
            for (int j = 0; j < 4; j++)
                win[k][j] = win[k][j+1];
        for (int k = 0; k < 4; k++)
            win[k][4] = (r - 4 + k) >= 0 ? longint'(rows_mem[(r - 4 + k) & 3][c]) : 0;
        win[4][4] = longint'(s);
        rows_mem[r & 3][c] = s;
        y0 = r - 2 < 0 ? 0 : r - 2;
        y1 = (r == h - 1) ? r : r - 2;
        x0 = c - 2 < 0 ? 0 : c - 2;
        x1 = (c == w - 1) ? c : c - 2;
        n  = 0;
        for (int y = y0; y <= y1; y++)
            for (int x = x0; x <= x1; x++) begin
                run[n].value = stencil_point(y, x, r, c, w, h);
                run[n].last  = 1'b0;
                run[n].eof   = (y == h - 1) && (x == w - 1);
                n++;
            end
        if (n > 0) run[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) points_due.push_back(run[i]);
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    task automatic report(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    initial begin
        errors    = 0;
        o_pending = 0;
        foreach (rows_mem[i, j]) rows_mem[i][j] = '0;
    end

    always @(posedge i_clk) begin
        t_point due;
        if (!i_rst_n) begin
            width_reg  = st25_pkg::C_WREG_BITS'(1024);
            height_reg = st25_pkg::C_ROW_BITS'(1024);
            col_pos    = 0;
            row_pos    = 0;
            foreach (win[k, j]) win[k][j] = 0;
            points_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == st25_pkg::C_REG_GRID_WIDTH)
                    width_reg = i_cfg_data[st25_pkg::C_WREG_BITS-1:0];
                else height_reg = i_cfg_data;
                col_pos = 0;
                row_pos = 0;
            end
            if (i_in_valid && !i_in_stall) predict_points(i_sample_in);
            if (i_out_valid && !i_out_stall) begin
                if (points_due.size() == 0) begin
                    report($sformatf("unexpected result %h", i_result_value));
                end else begin
                    due = points_due.pop_front();
                    if (i_result_value !== due.value)
                        report($sformatf("value %h, want %h", i_result_value, due.value));
                    if (i_last_of_run !== due.last)
                        report($sformatf("last_of_run %b, want %b", i_last_of_run, due.last));
                    if (i_end_of_frame !== due.eof)
                        report($sformatf("end_of_frame %b, want %b", i_end_of_frame, due.eof));
                end
            end
        end
        o_pending = points_due.size();
    end

endmodule

@@ sim/tb_stencil_25pt_clamped_2d.sv @@
`timescale 1ns / 100ps

module tb_stencil_25pt_clamped_2d;

    // generous: ~110 items, up to nine results each, with stall bursts
    localparam int CYCLE_LIMIT = 20000;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_stall;
    st25_pkg::t_sample           i_sample_in;
    logic                        o_out_valid;
    logic                        i_out_stall;
    st25_pkg::t_sample           o_result_value;
    logic                        o_last_of_run;
    logic                        o_end_of_frame;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [st25_pkg::C_CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [st25_pkg::C_CFG_DATA_BITS-1:0] i_cfg_data;

    int   errors;
    int   pending;
    int   cycles;
    int   stall_left;
    logic calm;          // no idling on either side when set

    stencil_25pt_clamped_2d DUT (.*);

    st25_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_sample_in    (i_sample_in),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_result_value (o_result_value),
        .i_last_of_run  (o_last_of_run),
        .i_end_of_frame (o_end_of_frame),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_errors       (errors),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // output stall in random bursts of random length, none while calm
    always @(posedge i_clk) begin
        int left;
        left = stall_left;
        if (left > 0) left--;
        else if (!calm && $urandom_range(0, 4) == 0) left = $urandom_range(1, 3);
        stall_left  <= left;
        i_out_stall <= (left > 0);
    end

    // mostly full-range words, with extremes and small values mixed in
    function automatic st25_pkg::t_sample pick_sample();
        case ($urandom_range(0, 5))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return st25_pkg::t_sample'($urandom_range(0, 255)) - 128;
            default: return st25_pkg::t_sample'($urandom);
        endcase
    endfunction

    task automatic send_item(input st25_pkg::t_sample s);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= s;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // leaves the write valid high; the caller drops it after the last write
    task automatic write_reg(input logic [st25_pkg::C_CFG_IDX_BITS-1:0] idx,
                             input logic [st25_pkg::C_CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // wait for every result, then cover the pipeline latency for runs with no result
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // sizes then n items; a partial frame is fine since the next write restarts it
    task automatic run_frame(input logic [15:0] w, input logic [15:0] h, input int n);
        write_reg(st25_pkg::C_REG_GRID_WIDTH, w);
        write_reg(st25_pkg::C_REG_GRID_HEIGHT, h);
        i_cfg_valid <= 1'b0;
        repeat (n) send_item(pick_sample());
        drain();
    endtask

    initial begin
        int w;
        int h;
        calm        = 1'b0;
        stall_left  = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_sample_in = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed 5x5 frame: a first row of mixed extremes, then blocks of max and min to hit both saturations
        write_reg(st25_pkg::C_REG_GRID_WIDTH, 16'd5);
        write_reg(st25_pkg::C_REG_GRID_HEIGHT, 16'd5);
        i_cfg_valid <= 1'b0;
        for (int i = 0; i < 25; i++) begin
            if (i == 0)       send_item(32'sh7fffffff);
            else if (i == 1)  send_item(32'sh80000000);
            else if (i == 2)  send_item(32'sh0);
            else if (i == 3)  send_item(-32'sh1);
            else if (i == 4)  send_item(32'sh1);
            else if (i < 13)  send_item(32'sh7fffffff);
            else if (i < 21)  send_item(32'sh80000000);
            else              send_item(st25_pkg::t_sample'($urandom));
        end
        drain();

        // zero sizes act as 1x1: every item is a whole frame
        run_frame(16'd0, 16'd0, 8);
        // width above the limit (all data bits set) saturates to the maximum width
        run_frame(16'hffff, 16'd3, 10);
        // tallest grid, only the top rows
        run_frame(16'd4, 16'hffff, 16);
        run_frame(16'd1, 16'd6, 6);
        run_frame(16'd7, 16'd2, 14);
        run_frame(16'd1024, 16'd1, 8);

        // random small frames, run whole
        repeat (2) begin
            w = $urandom_range(1, 4);
            h = $urandom_range(1, 3);
            run_frame(16'(w), 16'(h), w * h);
        end

        // last stretch with no idling
        calm = 1'b1;
        run_frame(16'd3, 16'd4, 12);

        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ stencil_25pt_clamped_2d.f @@
rtl/st25_pkg.sv
rtl/st25_ram.sv
rtl/stencil_25pt_clamped_2d.sv
sim/st25_checker.sv
sim/tb_stencil_25pt_clamped_2d.sv
